// ----- hw/rtl/gqlc_pkg.sv -----
// Package: shared types, register indexes and controller states for the glyph quad layout clip.
package gqlc_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned TexW   = 16;
  localparam int unsigned AddrW  = 5;

  typedef enum logic [1:0] {
    REQ_GLYPH   = 2'd0,
    REQ_NEWLINE = 2'd1,
    REQ_START   = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_MASK_LO_X = 3'd2,
    REG_MASK_LO_Y = 3'd3,
    REG_MASK_HI_X = 3'd4,
    REG_MASK_HI_Y = 3'd5,
    REG_WRAP_EN   = 3'd6,
    REG_WRAP_W    = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_PLACE,
    ST_SAT,
    ST_CLIP,
    ST_TEST,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;
    logic       wrap;
    logic       place;
    logic       sat;
    logic       clip;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_store;
    logic       out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_glyph;
    logic hidden;
    logic div_done;
  } sts_t;

  function automatic logic [CoordW-1:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) begin
      return 16'h7fff;
    end else if (v < -20'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

endpackage

// ----- hw/rtl/glyph_quad_layout_clip.sv -----
// Top level: glyph layout and mask clipping with register port.
//
//  channel | ports                 | direction
//  in      | in_valid/in_ready     | element in
//  out     | out_valid/out_ready   | clipped quad out
//  cfg     | psel..pready          | register access
//
// Newline, start and unused elements are taken in idle. A glyph passes through the wrap,
// place, saturate, clip and test states; a visible one then scales its four texture
// corners one after another in the bit-serial divider.
// Reset is synchronous; registers return to their defaults.
// A held result stalls the controller until taken.
module glyph_quad_layout_clip import gqlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [14:0] in_advance,
  input  logic signed [15:0] in_bearing_x,
  input  logic signed [15:0] in_bearing_y,
  input  logic [14:0] in_glyph_w,
  input  logic [14:0] in_glyph_h,
  input  logic [15:0] in_tex_low_u,
  input  logic [15:0] in_tex_low_v,
  input  logic [15:0] in_tex_high_u,
  input  logic [15:0] in_tex_high_v,
  input  logic signed [15:0] in_font_descender,
  input  logic [14:0] in_line_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_quad_x0,
  output logic signed [15:0] out_quad_y0,
  output logic signed [15:0] out_quad_x1,
  output logic signed [15:0] out_quad_y1,
  output logic [15:0] out_quad_u0,
  output logic [15:0] out_quad_v0,
  output logic [15:0] out_quad_u1,
  output logic [15:0] out_quad_v1,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic signed [15:0] ox_r, oy_r, mlx_r, mly_r, mhx_r, mhy_r;
  logic        we_r;
  logic [14:0] ww_r;
  reg_idx_t    ridx;
  logic        wr;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[AddrW-1:2]);
  assign wr     = psel && penable && pwrite && paddr[1:0] == 2'b00;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0; oy_r <= '0;
      mlx_r <= 16'h8000; mly_r <= 16'h8000;
      mhx_r <= 16'h7fff; mhy_r <= 16'h7fff;
      we_r <= 1'b0; ww_r <= 15'h7fff;
    end else if (wr) begin
      case (ridx)
        REG_ORIGIN_X:  ox_r  <= pwdata[15:0];
        REG_ORIGIN_Y:  oy_r  <= pwdata[15:0];
        REG_MASK_LO_X: mlx_r <= pwdata[15:0];
        REG_MASK_LO_Y: mly_r <= pwdata[15:0];
        REG_MASK_HI_X: mhx_r <= pwdata[15:0];
        REG_MASK_HI_Y: mhy_r <= pwdata[15:0];
        REG_WRAP_EN:   we_r  <= pwdata[0];
        REG_WRAP_W:    ww_r  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ORIGIN_X:  prdata = 32'(ox_r);
      REG_ORIGIN_Y:  prdata = 32'(oy_r);
      REG_MASK_LO_X: prdata = 32'(mlx_r);
      REG_MASK_LO_Y: prdata = 32'(mly_r);
      REG_MASK_HI_X: prdata = 32'(mhx_r);
      REG_MASK_HI_Y: prdata = 32'(mhy_r);
      REG_WRAP_EN:   prdata = {31'd0, we_r};
      REG_WRAP_W:    prdata = {17'd0, ww_r};
      default:       prdata = '0;
    endcase
  end

  cmd_t cmd;
  sts_t sts;

  gqlc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  gqlc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_req_type(in_req_type), .in_advance(in_advance),
    .in_bearing_x(in_bearing_x), .in_bearing_y(in_bearing_y),
    .in_glyph_w(in_glyph_w), .in_glyph_h(in_glyph_h),
    .in_tex_low_u(in_tex_low_u), .in_tex_low_v(in_tex_low_v),
    .in_tex_high_u(in_tex_high_u), .in_tex_high_v(in_tex_high_v),
    .in_font_descender(in_font_descender), .in_line_step(in_line_step),
    .origin_x(ox_r), .origin_y(oy_r),
    .mask_low_x(mlx_r), .mask_low_y(mly_r),
    .mask_high_x(mhx_r), .mask_high_y(mhy_r),
    .wrap_enable(we_r), .wrap_width(ww_r),
    .out_quad_x0(out_quad_x0), .out_quad_y0(out_quad_y0),
    .out_quad_x1(out_quad_x1), .out_quad_y1(out_quad_y1),
    .out_quad_u0(out_quad_u0), .out_quad_v0(out_quad_v0),
    .out_quad_u1(out_quad_u1), .out_quad_v1(out_quad_v1)
  );
endmodule

// ----- hw/rtl/gqlc_div.sv -----
// Iterative signed divider: one quotient bit a cycle, truncating toward zero.
module gqlc_div import gqlc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [33:0] num,
  input  logic        [16:0] den,
  output logic               done,
  output logic signed [33:0] quo
);
  logic [33:0] rem_r, rem_nxt, q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, neg_r, neg_nxt;
  logic [34:0] trial;
  logic [33:0] shifted;

  assign shifted = {rem_r[32:0], q_r[33]};
  assign trial   = {1'b0, shifted} - {18'd0, den};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done     = 1'b0;
    if (start) begin
      neg_nxt  = num[33];
      q_nxt    = num[33] ? 34'(-num) : num;
      rem_nxt  = '0;
      cnt_nxt  = 6'd34;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
        if (!trial[34]) begin
          rem_nxt = trial[33:0];
          q_nxt   = {q_r[32:0], 1'b1};
        end else begin
          rem_nxt = shifted;
          q_nxt   = {q_r[32:0], 1'b0};
        end
      end
    end
  end

  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
  end
endmodule

// ----- hw/rtl/gqlc_ctrl.sv -----
// Controller: sequences one element through layout, clipping and texture scaling.
module gqlc_ctrl import gqlc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t     state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = sts.is_glyph ? ST_WRAP : ST_IDLE;
        end
      end
      ST_WRAP:  state_nxt = ST_PLACE;
      ST_PLACE: state_nxt = ST_SAT;
      ST_SAT:   state_nxt = ST_CLIP;
      ST_CLIP:  state_nxt = ST_TEST;
      ST_TEST: begin
        sel_nxt   = 2'd0;
        state_nxt = sts.hidden ? ST_IDLE : ST_DIV_START;
      end
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = (sel_r == 2'd3) ? ST_OUT : ST_DIV_START;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = sel_r;
    in_ready      = (state_r == ST_IDLE);
    cmd.load      = in_valid && in_ready;
    cmd.wrap      = (state_r == ST_WRAP);
    cmd.place     = (state_r == ST_PLACE);
    cmd.sat       = (state_r == ST_SAT);
    cmd.clip      = (state_r == ST_CLIP);
    cmd.div_start = (state_r == ST_DIV_START);
    cmd.div_store = (state_r == ST_DIV_WAIT) && sts.div_done;
    cmd.out_load  = (state_r == ST_OUT) && (!ov_r || out_ready);
    ov_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

// ----- hw/rtl/gqlc_dp.sv -----
// Datapath: pen state, box placement, clipping and texture scaling.
module gqlc_dp import gqlc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic [1:0]  in_req_type,
  input  logic [14:0] in_advance,
  input  logic signed [15:0] in_bearing_x,
  input  logic signed [15:0] in_bearing_y,
  input  logic [14:0] in_glyph_w,
  input  logic [14:0] in_glyph_h,
  input  logic [15:0] in_tex_low_u,
  input  logic [15:0] in_tex_low_v,
  input  logic [15:0] in_tex_high_u,
  input  logic [15:0] in_tex_high_v,
  input  logic signed [15:0] in_font_descender,
  input  logic [14:0] in_line_step,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  input  logic signed [15:0] mask_low_x,
  input  logic signed [15:0] mask_low_y,
  input  logic signed [15:0] mask_high_x,
  input  logic signed [15:0] mask_high_y,
  input  logic        wrap_enable,
  input  logic [14:0] wrap_width,
  output logic signed [15:0] out_quad_x0,
  output logic signed [15:0] out_quad_y0,
  output logic signed [15:0] out_quad_x1,
  output logic signed [15:0] out_quad_y1,
  output logic [15:0] out_quad_u0,
  output logic [15:0] out_quad_v0,
  output logic [15:0] out_quad_u1,
  output logic [15:0] out_quad_v1
);
  logic signed [15:0] pen_x_r, pen_y_r;
  logic [14:0] adv_r, gw_r, gh_r, ls_r;
  logic signed [15:0] bx_r, by_r, desc_r;
  logic [15:0] u0_r, v0_r, u1_r, v1_r;
  logic signed [19:0] px_r, py_r;
  logic signed [15:0] x0_r, y0_r, x1_r, y1_r, kx0_r, ky0_r, kx1_r, ky1_r;
  logic [15:0] ru0_r, rv0_r, ru1_r, rv1_r;
  logic [15:0] qx0_r, qy0_r, qx1_r, qy1_r, qu0_r, qv0_r, qu1_r, qv1_r;

  logic signed [16:0] pen_y_ls;
  logic signed [16:0] pen_x_adv;
  logic               wrap_hit;

  assign pen_y_ls  = 17'(pen_y_r) + $signed({2'b00, ls_r});
  assign pen_x_adv = 17'(pen_x_r) + $signed({2'b00, adv_r});
  assign wrap_hit  = wrap_enable && (pen_x_adv > $signed({2'b00, wrap_width}));

  // Divider operand selection.
  logic signed [16:0] t0, t1, off, size;
  logic signed [33:0] num;
  logic signed [33:0] quo;
  logic        div_done;
  logic signed [17:0] dlt;

  always_comb begin
    case (cmd.div_sel)
      2'd0: begin
        t0 = {1'b0, u0_r}; t1 = {1'b0, u1_r};
        off = 17'(kx0_r) - 17'(x0_r); size = 17'(x1_r) - 17'(x0_r);
      end
      2'd1: begin
        t0 = {1'b0, v0_r}; t1 = {1'b0, v1_r};
        off = 17'(ky0_r) - 17'(y0_r); size = 17'(y1_r) - 17'(y0_r);
      end
      2'd2: begin
        t0 = {1'b0, u0_r}; t1 = {1'b0, u1_r};
        off = 17'(kx1_r) - 17'(x0_r); size = 17'(x1_r) - 17'(x0_r);
      end
      default: begin
        t0 = {1'b0, v0_r}; t1 = {1'b0, v1_r};
        off = 17'(ky1_r) - 17'(y0_r); size = 17'(y1_r) - 17'(y0_r);
      end
    endcase
    dlt = 18'(t1) - 18'(t0);
    num = 34'(dlt) * 34'($signed({1'b0, off}));
  end

  logic div_go;
  assign div_go = cmd.div_start && (size > 17'sd0);

  gqlc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (num),
    .den   (size),
    .done  (div_done),
    .quo   (quo)
  );

  logic pass_r;
  logic [15:0] scaled;
  // Zero-size axis: pass the selected corner through.
  always_comb begin
    if (pass_r) begin
      scaled = cmd.div_sel[1] ? t1[15:0] : t0[15:0];
    end else begin
      scaled = 16'(t0[15:0] + quo[15:0]);
    end
  end

  assign sts.is_glyph = (in_req_type == REQ_GLYPH);
  assign sts.hidden   = (kx0_r > kx1_r) || (ky0_r > ky1_r);
  assign sts.div_done = div_done || (pass_r && !cmd.div_start && !div_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
      pass_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        case (in_req_type)
          REQ_START: begin
            pen_x_r <= '0;
            pen_y_r <= $signed({1'b0, in_line_step});
          end
          REQ_NEWLINE: begin
            pen_x_r <= '0;
            pen_y_r <= sat16(20'(17'(pen_y_r) + $signed({2'b00, in_line_step})));
          end
          default: ;
        endcase
      end
      if (cmd.wrap && wrap_hit) begin
        pen_x_r <= '0;
        pen_y_r <= sat16(20'(pen_y_ls));
      end
      if (cmd.place) begin
        pen_x_r <= sat16(20'(pen_x_adv));
      end
      if (cmd.div_start) begin
        pass_r <= !(size > 17'sd0);
      end else if (cmd.div_store) begin
        pass_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      adv_r <= in_advance; gw_r <= in_glyph_w; gh_r <= in_glyph_h; ls_r <= in_line_step;
      bx_r <= in_bearing_x; by_r <= in_bearing_y; desc_r <= in_font_descender;
      u0_r <= in_tex_low_u; v0_r <= in_tex_low_v;
      u1_r <= in_tex_high_u; v1_r <= in_tex_high_v;
    end
    if (cmd.place) begin
      px_r <= 20'(origin_x) + 20'(pen_x_r) + 20'(bx_r);
      py_r <= 20'(origin_y) + 20'(pen_y_r) - 20'(desc_r) - 20'(by_r)
              - $signed({5'd0, gh_r});
    end
    if (cmd.sat) begin
      x0_r <= sat16(px_r);
      y0_r <= sat16(py_r);
      x1_r <= sat16(px_r + $signed({5'd0, gw_r}));
      y1_r <= sat16(py_r + $signed({5'd0, gh_r}));
    end
    if (cmd.clip) begin
      kx0_r <= (x0_r > mask_low_x) ? x0_r : mask_low_x;
      ky0_r <= (y0_r > mask_low_y) ? y0_r : mask_low_y;
      kx1_r <= (x1_r < mask_high_x) ? x1_r : mask_high_x;
      ky1_r <= (y1_r < mask_high_y) ? y1_r : mask_high_y;
    end
    if (cmd.div_store) begin
      case (cmd.div_sel)
        2'd0:    ru0_r <= scaled;
        2'd1:    rv0_r <= scaled;
        2'd2:    ru1_r <= scaled;
        default: rv1_r <= scaled;
      endcase
    end
    if (cmd.out_load) begin
      qx0_r <= kx0_r; qy0_r <= ky0_r; qx1_r <= kx1_r; qy1_r <= ky1_r;
      qu0_r <= ru0_r; qv0_r <= rv0_r; qu1_r <= ru1_r; qv1_r <= rv1_r;
    end
  end

  assign out_quad_x0 = qx0_r;
  assign out_quad_y0 = qy0_r;
  assign out_quad_x1 = qx1_r;
  assign out_quad_y1 = qy1_r;
  assign out_quad_u0 = qu0_r;
  assign out_quad_v0 = qv0_r;
  assign out_quad_u1 = qu1_r;
  assign out_quad_v1 = qv1_r;
endmodule

// ----- dv/glyph_quad_layout_clip_tb.sv -----
// Testbench for glyph_quad_layout_clip: random layout streams checked against a quad predictor.
`timescale 1ns / 1ps

import gqlc_pkg::*;

typedef struct {
  req_t                kind;
  logic [14:0]         advance;
  logic signed [15:0]  bearing_x;
  logic signed [15:0]  bearing_y;
  logic [14:0]         glyph_w;
  logic [14:0]         glyph_h;
  logic [15:0]         tex_low_u;
  logic [15:0]         tex_low_v;
  logic [15:0]         tex_high_u;
  logic [15:0]         tex_high_v;
  logic signed [15:0]  descender;
  logic [14:0]         line_step;
} text_elem_t;

typedef struct {
  logic [15:0] x0, y0, x1, y1, u0, v0, u1, v1;
} quad_t;

class quad_scoreboard;
  longint origin_x, origin_y, mask_lo_x, mask_lo_y, mask_hi_x, mask_hi_y;
  longint wrap_en, wrap_w, pen_x, pen_y;
  quad_t  pending_quads[$];
  int     errors;

  function new();
    origin_x = 0; origin_y = 0;
    mask_lo_x = -32768; mask_lo_y = -32768;
    mask_hi_x = 32767;  mask_hi_y = 32767;
    wrap_en = 0; wrap_w = 32767;
    pen_x = 0; pen_y = 0;
    errors = 0;
  endfunction

  function longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function longint scale_tex(longint t0, longint t1, longint off, longint size);
    if (size <= 0) return t0;
    return t0 + ((t1 - t0) * off) / size;
  endfunction

  function void set_reg(reg_idx_t idx, logic [31:0] val);
    case (idx)
      REG_ORIGIN_X:  origin_x  = longint'($signed(val[15:0]));
      REG_ORIGIN_Y:  origin_y  = longint'($signed(val[15:0]));
      REG_MASK_LO_X: mask_lo_x = longint'($signed(val[15:0]));
      REG_MASK_LO_Y: mask_lo_y = longint'($signed(val[15:0]));
      REG_MASK_HI_X: mask_hi_x = longint'($signed(val[15:0]));
      REG_MASK_HI_Y: mask_hi_y = longint'($signed(val[15:0]));
      REG_WRAP_EN:   wrap_en   = val[0];
      REG_WRAP_W:    wrap_w    = val[14:0];
      default: ;
    endcase
  endfunction

  // Advance the pen and queue the clipped quad, if any.
  function void note_element(text_elem_t e);
    longint adv, gw, gh, ls, px, py, x0, y0, x1, y1, kx0, ky0, kx1, ky1;
    longint u0, v0, u1, v1;
    quad_t q;
    adv = e.advance; gw = e.glyph_w; gh = e.glyph_h; ls = e.line_step;
    u0 = e.tex_low_u; v0 = e.tex_low_v; u1 = e.tex_high_u; v1 = e.tex_high_v;
    if (e.kind == REQ_START) begin
      pen_x = 0; pen_y = ls;
      return;
    end
    if (e.kind == REQ_NEWLINE) begin
      pen_x = 0; pen_y = clamp16(pen_y + ls);
      return;
    end
    if (e.kind != REQ_GLYPH) return;
    if (wrap_en != 0 && pen_x + adv > wrap_w) begin
      pen_x = 0; pen_y = clamp16(pen_y + ls);
    end
    px = origin_x + pen_x + longint'(e.bearing_x);
    py = origin_y + pen_y - longint'(e.descender) - (longint'(e.bearing_y) + gh);
    pen_x = clamp16(pen_x + adv);
    x0 = clamp16(px); y0 = clamp16(py);
    x1 = clamp16(px + gw); y1 = clamp16(py + gh);
    kx0 = (x0 > mask_lo_x) ? x0 : mask_lo_x;
    ky0 = (y0 > mask_lo_y) ? y0 : mask_lo_y;
    kx1 = (x1 < mask_hi_x) ? x1 : mask_hi_x;
    ky1 = (y1 < mask_hi_y) ? y1 : mask_hi_y;
    if (kx0 > kx1 || ky0 > ky1) return;
    q.x0 = kx0[15:0]; q.y0 = ky0[15:0]; q.x1 = kx1[15:0]; q.y1 = ky1[15:0];
    q.u0 = 16'(scale_tex(u0, u1, kx0 - x0, x1 - x0));
    q.v0 = 16'(scale_tex(v0, v1, ky0 - y0, y1 - y0));
    q.u1 = 16'((x1 - x0 > 0) ? scale_tex(u0, u1, kx1 - x0, x1 - x0) : u1);
    q.v1 = 16'((y1 - y0 > 0) ? scale_tex(v0, v1, ky1 - y0, y1 - y0) : v1);
    pending_quads.insert(pending_quads.size(), q);
  endfunction

  function void cmp(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  function void check_quad(quad_t got);
    quad_t want;
    if (pending_quads.size() == 0) begin
      $error("quad transfer with nothing expected");
      errors++;
      return;
    end
    want = pending_quads.pop_front();
    cmp("quad_x0", want.x0, got.x0);
    cmp("quad_y0", want.y0, got.y0);
    cmp("quad_x1", want.x1, got.x1);
    cmp("quad_y1", want.y1, got.y1);
    cmp("quad_u0", want.u0, got.u0);
    cmp("quad_v0", want.v0, got.v0);
    cmp("quad_u1", want.u1, got.u1);
    cmp("quad_v1", want.v1, got.v1);
  endfunction
endclass

module glyph_quad_layout_clip_tb;
  localparam longint CycleLimit = 3000000;
  localparam int     DrainCycles = 250;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0]  in_req_type = '0;
  logic [14:0] in_advance = '0;
  logic signed [15:0] in_bearing_x = '0;
  logic signed [15:0] in_bearing_y = '0;
  logic [14:0] in_glyph_w = '0;
  logic [14:0] in_glyph_h = '0;
  logic [15:0] in_tex_low_u = '0;
  logic [15:0] in_tex_low_v = '0;
  logic [15:0] in_tex_high_u = '0;
  logic [15:0] in_tex_high_v = '0;
  logic signed [15:0] in_font_descender = '0;
  logic [14:0] in_line_step = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] out_quad_x0, out_quad_y0, out_quad_x1, out_quad_y1;
  logic [15:0] out_quad_u0, out_quad_v0, out_quad_u1, out_quad_v1;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  quad_scoreboard sb = new();
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  longint cycles = 0;

  glyph_quad_layout_clip dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Check the quad transfer of this edge, then pick next cycle's ready.
  always @(posedge clk) begin
    quad_t got;
    if (rst_n && out_valid && out_ready) begin
      got.x0 = out_quad_x0; got.y0 = out_quad_y0;
      got.x1 = out_quad_x1; got.y1 = out_quad_y1;
      got.u0 = out_quad_u0; got.v0 = out_quad_v0;
      got.u1 = out_quad_u1; got.v1 = out_quad_v1;
      sb.check_quad(got);
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic text_elem_t mk(req_t k, int adv, int bx, int by, int w, int h,
                                    int u0, int v0, int u1, int v1, int desc, int ls);
    text_elem_t e;
    e.kind = k; e.advance = 15'(adv); e.bearing_x = 16'(bx); e.bearing_y = 16'(by);
    e.glyph_w = 15'(w); e.glyph_h = 15'(h); e.tex_low_u = 16'(u0); e.tex_low_v = 16'(v0);
    e.tex_high_u = 16'(u1); e.tex_high_v = 16'(v1); e.descender = 16'(desc);
    e.line_step = 15'(ls);
    return e;
  endfunction

  function automatic text_elem_t random_elem();
    text_elem_t e;
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      // raw bits, any field value
      e = mk(REQ_GLYPH, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      e.kind = req_t'(pick < 2 ? REQ_UNUSED : REQ_GLYPH);
      if (pick >= 12) e.kind = req_t'(2'($urandom_range(3)));
    end else begin
      e = mk(REQ_GLYPH, $urandom_range(400), $urandom_range(250) - 50,
             $urandom_range(400) - 100, $urandom_range(400), $urandom_range(400),
             $urandom, $urandom, $urandom, $urandom,
             $urandom_range(200) - 100, $urandom_range(100, 400));
      if (pick < 23) e.kind = REQ_NEWLINE;
      else if (pick < 28) e.kind = REQ_START;
    end
    return e;
  endfunction

  // Hold valid and payload until the transfer.
  task automatic send(text_elem_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= e.kind; in_advance <= e.advance;
    in_bearing_x <= e.bearing_x; in_bearing_y <= e.bearing_y;
    in_glyph_w <= e.glyph_w; in_glyph_h <= e.glyph_h;
    in_tex_low_u <= e.tex_low_u; in_tex_low_v <= e.tex_low_v;
    in_tex_high_u <= e.tex_high_u; in_tex_high_v <= e.tex_high_v;
    in_font_descender <= e.descender; in_line_step <= e.line_step;
    do @(posedge clk); while (!in_ready);
    sb.note_element(e);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_quads.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= AddrW'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic write_setup(int ox, int oy, int lx, int ly, int hx, int hy, int we, int ww);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_MASK_LO_X, lx);
    write_reg(REG_MASK_LO_Y, ly);
    write_reg(REG_MASK_HI_X, hx);
    write_reg(REG_MASK_HI_Y, hy);
    write_reg(REG_WRAP_EN, we);
    write_reg(REG_WRAP_W, ww);
  endtask

  task automatic run_random(int n);
    repeat (n) send(random_elem());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset setup: open mask, no wrapping.
    send(mk(REQ_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 256));
    send(mk(REQ_GLYPH, 160, 16, 200, 128, 192, 1000, 2000, 30000, 40000, -40, 256));
    send(mk(REQ_GLYPH, 0, 0, 0, 0, 0, 12345, 54321, 65535, 0, 0, 256));
    send(mk(REQ_GLYPH, 100, 32767, 0, 32767, 50, 0, 0, 65535, 65535, 0, 256));
    send(mk(REQ_GLYPH, 32767, -32768, 32767, 32767, 32767, 0, 65535, 65535, 0,
            -32768, 32767));
    send(mk(REQ_GLYPH, 32767, 0, -32768, 0, 32767, 65535, 65535, 0, 0, 32767, 0));
    send(mk(REQ_NEWLINE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32767));
    send(mk(REQ_NEWLINE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_UNUSED, 32767, -1, -1, 32767, 32767, 65535, 65535, 65535, 65535, -1,
            32767));
    send(mk(REQ_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_GLYPH, 50, -16, 100, 200, 200, 40000, 10000, 2000, 60000, 20, 0));
    run_random(350);
    drain();

    // Tight mask with wrapping: partial and hidden glyphs.
    send_idle_pct = 63;
    write_setup(100, 200, -200, -100, 1600, 800, 1, 1200);
    send(mk(REQ_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 300));
    send(mk(REQ_GLYPH, 200, -400, 0, 400, 300, 0, 0, 65535, 65535, 0, 300));
    send(mk(REQ_GLYPH, 200, 3000, 0, 100, 100, 0, 0, 65535, 65535, 0, 300));
    send(mk(REQ_GLYPH, 1300, 0, -1000, 100, 900, 100, 65000, 65000, 100, 0, 300));
    run_random(500);
    drain();

    // Extremes: origin at the top end, zero wrap width.
    send_idle_pct = 0;
    recv_stall_pct = 63;
    write_setup(32767, 32767, -32768, -32768, 32767, 32767, 1, 0);
    run_random(300);
    drain();

    // Inverted mask hides everything.
    write_setup(-32768, -32768, 500, 500, -500, -500, 0, 32767);
    run_random(80);
    drain();

    // Narrow mask around the origin.
    send_idle_pct = 23;
    recv_stall_pct = 23;
    write_setup(-32768, 0, -32768, 0, 2000, 1500, 1, 32767);
    run_random(200);
    drain();
    write_setup(-300, -500, -100, -200, 900, 700, 1, 2400);
    run_random(500);
    drain();

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
